// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/brrg_pkg.sv
// ----------------------------------------------------------------------------
// brrg_pkg
// Shared constants, datapath operation codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package brrg_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = DATA_W / 2;
    localparam int CNT_W  = $clog2(DATA_W);
    localparam int ADDR_W = 4;

    // Address bit that selects between the two 64-bit registers (8-byte stride)
    localparam int CFG_SEL_BIT = 3;
    localparam logic CFG_SEL_SEED = 1'b0;
    localparam logic CFG_SEL_SALT = 1'b1;

    // Last divider iteration and last multiply step
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);
    localparam logic [1:0]       MUL_LAST = 2'd3;

    // Mixing constants
    localparam logic [DATA_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [DATA_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [DATA_W-1:0] GOLDEN_ADD  = 64'h9E3779B97F4A7C15;
    localparam logic [DATA_W-1:0] SEED_FALLBK = 64'hD1B54A32D192ED03;
    localparam logic [DATA_W-1:0] ZERO_FALLBK = 64'hA0761D6478BD642F;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,          // latch ordered bounds and range size
        OP_DIV_INIT_MAX,  // divider on all-ones (rejection limit)
        OP_DIV_INIT_X,    // divider on the accepted draw
        OP_DIV_STEP,      // one restoring division bit
        OP_LIMIT,         // limit = all-ones minus remainder
        OP_M_SEED,        // mix operand from seed register
        OP_S_FROM_M,      // working state from seeded mix, with fallback
        OP_S_FROM_STATE,  // working state from generator state
        OP_MIX_IN,        // bump counter, fold in counter and salt, add golden
        OP_XS30,
        OP_XS27,
        OP_XS31,
        OP_MUL,           // one step of the 64-bit truncated multiply
        OP_S_XOR_M,       // s ^= m, then m = s
        OP_FINISH         // zero fix-up, commit generator state
    } dp_op_t;

    // A separate flag for the output load keeps the enum at 16 codes
    typedef struct packed {
        dp_op_t     op;
        logic       mul_b;     // multiply by MIX_MUL_B rather than MIX_MUL_A
        logic [1:0] step;      // multiply step
        logic       result;    // load output register
    } dp_cmd_t;

    typedef struct packed {
        logic state_zero;   // generator unseeded
        logic full;         // range spans all 2^64 values
        logic reject;       // draw at or above limit
        logic out_free;     // output register can take a result
    } dp_stat_t;

    typedef struct packed {
        logic              seed_we;
        logic              salt_we;
        logic [DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// File: src/bounded_random_range_generator.sv
// A bounded request runs: load, limit division, one or more draws, reduction
// and output load; a rejected draw repeats the draw, and the first draw from an
// unseeded state first finalises the seed register. A full 64-bit span skips both divisions.
// One request at a time: a new request is taken only once the result is loaded.
// Reset (rst_n, asynchronous, active low) clears registers, state and counter.
// ----------------------------------------------------------------------------
// bounded_random_range_generator
// Uniform 64-bit values over an inclusive range, splitmix64 mixing with
// rejection sampling; APB register port and stream request/result channels.
// ----------------------------------------------------------------------------
module bounded_random_range_generator
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [brrg_pkg::ADDR_W-1:0]    paddr,
    input  logic [brrg_pkg::DATA_W-1:0]    pwdata,
    output logic [brrg_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    // Request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [2*brrg_pkg::DATA_W-1:0]  s_axis_tdata,  // range_low, range_high
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [brrg_pkg::DATA_W-1:0]    m_axis_tdata   // random_value
);
    import brrg_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    cfg_wr_t           cfg;
    logic              wr_en;
    logic [DATA_W-1:0] seed_q, salt_q;

    // Register write decode
    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite && pready;
    assign cfg.seed_we = wr_en && (paddr[CFG_SEL_BIT] == CFG_SEL_SEED);
    assign cfg.salt_we = wr_en && (paddr[CFG_SEL_BIT] == CFG_SEL_SALT);
    assign cfg.data    = pwdata;

    // Register read mux
    assign prdata = (paddr[CFG_SEL_BIT] == CFG_SEL_SALT) ? salt_q : seed_q;

    brrg_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    brrg_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg          (cfg),
        .seed_value   (seed_q),
        .address_salt (salt_q),
        .range_low    (s_axis_tdata[DATA_W-1:0]),
        .range_high   (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .random_value (m_axis_tdata)
    );

endmodule

// File: src/brrg_ctrl.sv
// ----------------------------------------------------------------------------
// brrg_ctrl
// Sequencer: range set-up, limit division, draw mixing, rejection, reduction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brrg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  brrg_pkg::dp_stat_t stat,
    output brrg_pkg::dp_cmd_t  cmd
);
    import brrg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RANGE,
        ST_LIM_DIV,
        ST_LIM_SET,
        ST_DRAW,
        ST_SEEDED,
        ST_MIX,
        ST_XS30,
        ST_MULA,
        ST_XS27,
        ST_MULB,
        ST_XS31,
        ST_XORM,
        ST_FINISH,
        ST_CHECK,
        ST_RED_DIV,
        ST_RESULT
    } state_t;

    // Which finaliser pass is running
    typedef enum logic [1:0] {
        PASS_SEED,
        PASS_ONE,
        PASS_TWO
    } pass_t;

    state_t            state_reg, state_next;
    pass_t             pass_reg, pass_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = '0;
        cmd        = '{op: OP_NONE, mul_b: 1'b0, step: cnt_reg[1:0], result: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (stat.full)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    cmd.op     = OP_DIV_INIT_MAX;
                    state_next = ST_LIM_DIV;
                end
            end
            ST_LIM_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_LIM_SET;
                end
            end
            ST_LIM_SET:
            begin
                cmd.op     = OP_LIMIT;
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (stat.state_zero)
                begin
                    cmd.op     = OP_M_SEED;
                    pass_next  = PASS_SEED;
                    state_next = ST_XS30;
                end
                else
                begin
                    cmd.op     = OP_S_FROM_STATE;
                    state_next = ST_MIX;
                end
            end
            ST_SEEDED:
            begin
                cmd.op     = OP_S_FROM_M;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                cmd.op     = OP_MIX_IN;
                pass_next  = PASS_ONE;
                state_next = ST_XS30;
            end
            ST_XS30:
            begin
                cmd.op     = OP_XS30;
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                cmd.op   = OP_MUL;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_XS27;
                end
            end
            ST_XS27:
            begin
                cmd.op     = OP_XS27;
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                cmd.op    = OP_MUL;
                cmd.mul_b = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == MUL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_XS31;
                end
            end
            ST_XS31:
            begin
                cmd.op = OP_XS31;
                case (pass_reg)
                    PASS_SEED: state_next = ST_SEEDED;
                    PASS_ONE:  state_next = ST_XORM;
                    PASS_TWO:  state_next = ST_FINISH;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_XORM:
            begin
                cmd.op     = OP_S_XOR_M;
                pass_next  = PASS_TWO;
                state_next = ST_XS30;
            end
            ST_FINISH:
            begin
                cmd.op     = OP_FINISH;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.full)
                begin
                    state_next = ST_RESULT;
                end
                else if (stat.reject)
                begin
                    state_next = ST_DRAW;
                end
                else
                begin
                    cmd.op     = OP_DIV_INIT_X;
                    state_next = ST_RED_DIV;
                end
            end
            ST_RED_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.result = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // State, pass and step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= PASS_SEED;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
        end
    end

    `ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, state_reg == ST_RANGE,
        "accepted request did not start range set-up")
    `ASSERT_IMP(a_result_free, cmd.result, stat.out_free && state_reg == ST_RESULT,
        "result loaded while output register busy")

endmodule

// File: src/brrg_dp.sv
// ----------------------------------------------------------------------------
// brrg_dp
// Datapath: generator state, mixing with a shared 32x32 multiplier,
// bit-serial remainder unit, configuration registers and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brrg_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  brrg_pkg::dp_cmd_t            cmd,
    output brrg_pkg::dp_stat_t           stat,
    input  brrg_pkg::cfg_wr_t            cfg,
    output logic [brrg_pkg::DATA_W-1:0]  seed_value,
    output logic [brrg_pkg::DATA_W-1:0]  address_salt,
    input  logic [brrg_pkg::DATA_W-1:0]  range_low,
    input  logic [brrg_pkg::DATA_W-1:0]  range_high,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [brrg_pkg::DATA_W-1:0]  random_value
);
    import brrg_pkg::*;

    // Architectural state (reset)
    logic [DATA_W-1:0] seed_reg, seed_next;
    logic [DATA_W-1:0] salt_reg, salt_next;
    logic [DATA_W-1:0] gen_reg, gen_next;
    logic [DATA_W-1:0] ctr_reg, ctr_next;
    logic              full_reg, full_next;
    logic              ovalid_reg, ovalid_next;

    // Working registers (no reset)
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] size_reg, size_next;
    logic [DATA_W-1:0] limit_reg, limit_next;
    logic [DATA_W-1:0] s_reg, s_next;
    logic [DATA_W-1:0] m_reg, m_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] pp_reg, pp_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] out_reg, out_next;

    logic              swap;
    logic [DATA_W-1:0] bmin, bmax, span;
    logic [DATA_W-1:0] mul_k;
    logic [HALF_W-1:0] mul_x, mul_y;
    logic [DATA_W-1:0] acc_sum;
    logic [DATA_W:0]   div_t, div_d;
    logic [DATA_W-1:0] ctr_inc, mixed, fixed;

    // Range ordering
    assign swap = range_low > range_high;
    assign bmin = swap ? range_high : range_low;
    assign bmax = swap ? range_low : range_high;
    assign span = bmax - bmin;

    // Multiply operands: lo*lo, lo*hi, hi*lo of the truncated 64x64 product
    assign mul_k   = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_x   = (cmd.step == 2'd2) ? m_reg[DATA_W-1:HALF_W] : m_reg[HALF_W-1:0];
    assign mul_y   = (cmd.step == 2'd1) ? mul_k[DATA_W-1:HALF_W] : mul_k[HALF_W-1:0];
    assign acc_sum = acc_reg + {pp_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    // Restoring division step
    assign div_t = {rem_reg, dvd_reg[DATA_W-1]};
    assign div_d = div_t - {1'b0, size_reg};

    assign ctr_inc = ctr_reg + 1'b1;
    assign mixed   = s_reg ^ ctr_inc ^ {salt_reg[DATA_W-8:0], salt_reg[DATA_W-1:DATA_W-7]};
    assign fixed   = (m_reg == '0) ? (ZERO_FALLBK ^ ctr_reg) : m_reg;

    // Operation decode
    always_comb
    begin
        seed_next   = cfg.seed_we ? cfg.data : seed_reg;
        salt_next   = cfg.salt_we ? cfg.data : salt_reg;
        gen_next    = gen_reg;
        ctr_next    = ctr_reg;
        full_next   = full_reg;
        lo_next     = lo_reg;
        size_next   = size_reg;
        limit_next  = limit_reg;
        s_next      = s_reg;
        m_next      = m_reg;
        acc_next    = acc_reg;
        pp_next     = pp_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg && !out_ready;

        case (cmd.op)
            OP_NONE: ;
            OP_LOAD:
            begin
                lo_next   = bmin;
                size_next = span + 1'b1;
                full_next = &span;
            end
            OP_DIV_INIT_MAX:
            begin
                rem_next = '0;
                dvd_next = '1;
            end
            OP_DIV_INIT_X:
            begin
                rem_next = '0;
                dvd_next = gen_reg;
            end
            OP_DIV_STEP:
            begin
                rem_next = div_d[DATA_W] ? div_t[DATA_W-1:0] : div_d[DATA_W-1:0];
                dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            end
            OP_LIMIT:        limit_next = ~rem_reg;
            OP_M_SEED:       m_next = seed_reg;
            OP_S_FROM_M:     s_next = (m_reg == '0) ? SEED_FALLBK : m_reg;
            OP_S_FROM_STATE: s_next = gen_reg;
            OP_MIX_IN:
            begin
                ctr_next = ctr_inc;
                s_next   = mixed;
                m_next   = mixed + GOLDEN_ADD;
            end
            OP_XS30: m_next = m_reg ^ (m_reg >> 30);
            OP_XS27: m_next = m_reg ^ (m_reg >> 27);
            OP_XS31: m_next = m_reg ^ (m_reg >> 31);
            OP_MUL:
            begin
                pp_next = DATA_W'(mul_x * mul_y);
                case (cmd.step)
                    2'd0:    ;
                    2'd1:    acc_next = pp_reg;
                    2'd2:    acc_next = acc_sum;
                    default: m_next   = acc_sum;
                endcase
            end
            OP_S_XOR_M:
            begin
                s_next = s_reg ^ m_reg;
                m_next = s_reg ^ m_reg;
            end
            OP_FINISH: gen_next = fixed;
            default: ;
        endcase

        // Output register load
        if (cmd.result)
        begin
            out_next    = full_reg ? gen_reg : lo_reg + rem_reg;
            ovalid_next = 1'b1;
        end
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            salt_reg   <= '0;
            gen_reg    <= '0;
            ctr_reg    <= '0;
            full_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            seed_reg   <= seed_next;
            salt_reg   <= salt_next;
            gen_reg    <= gen_next;
            ctr_reg    <= ctr_next;
            full_reg   <= full_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        size_reg  <= size_next;
        limit_reg <= limit_next;
        s_reg     <= s_next;
        m_reg     <= m_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        out_reg   <= out_next;
    end

    assign stat.state_zero = (gen_reg == '0);
    assign stat.full       = full_reg;
    assign stat.reject     = (gen_reg >= limit_reg);
    assign stat.out_free   = !ovalid_reg || out_ready;

    assign seed_value   = seed_reg;
    assign address_salt = salt_reg;
    assign out_valid    = ovalid_reg;
    assign random_value = out_reg;

    `ASSERT_NXT(a_state_nonzero, cmd.op == OP_FINISH, gen_reg != '0,
        "generator state zero after a draw")
    `ASSERT_IMP(a_rem_bound, cmd.op == OP_DIV_STEP && !full_reg, rem_reg < size_reg,
        "partial remainder not below range size")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounded random range generator. A scoreboard
// class mirrors the mixer state, draw counter and rejection loop and predicts
// every result. Directed ranges are followed by random phases under several
// register settings and flow-control patterns, including one long result
// hold-off.
// ----------------------------------------------------------------------------

// Predicts each result of the generator and checks the results received
class range_draw_scoreboard;

    bit [63:0] seed_reg;
    bit [63:0] salt_reg;
    bit [63:0] mix_state;
    bit [63:0] draw_count;
    bit [63:0] pending_values[$];
    int        failures;

    function new();
        seed_reg   = '0;
        salt_reg   = '0;
        mix_state  = '0;
        draw_count = '0;
        failures   = 0;
    endfunction

    // splitmix64 finaliser
    function bit [63:0] finalise(bit [63:0] v);
        v = v ^ (v >> 30);
        v = v * brrg_pkg::MIX_MUL_A;
        v = v ^ (v >> 27);
        v = v * brrg_pkg::MIX_MUL_B;
        v = v ^ (v >> 31);
        return v;
    endfunction

    // One raw draw; advances state and counter
    function bit [63:0] next_draw();
        bit [63:0] s;
        s = mix_state;
        if (s == '0)
        begin
            s = finalise(seed_reg);
            if (s == '0)
                s = brrg_pkg::SEED_FALLBK;
        end
        draw_count = draw_count + 64'd1;
        s = s ^ draw_count;
        s = s ^ {salt_reg[56:0], salt_reg[63:57]};
        s = s ^ finalise(s + brrg_pkg::GOLDEN_ADD);
        s = finalise(s);
        if (s == '0)
            s = brrg_pkg::ZERO_FALLBK ^ draw_count;
        mix_state = s;
        return s;
    endfunction

    function void note_failure(string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Accepted request: order bounds, draw with rejection, queue the value
    function void note_request(bit [63:0] lo, bit [63:0] hi);
        bit [63:0] t;
        bit [63:0] size;
        bit [63:0] limit;
        bit [63:0] x;
        if (lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        size = hi - lo + 64'd1;
        if (size == '0)
        begin
            pending_values.push_back(next_draw());
        end
        else
        begin
            limit = 64'hFFFF_FFFF_FFFF_FFFF - (64'hFFFF_FFFF_FFFF_FFFF % size);
            x = next_draw();
            while (x >= limit)
                x = next_draw();
            pending_values.push_back(lo + (x % size));
        end
    endfunction

    // Result received: compare with the oldest expected value
    function void check_value(bit [63:0] actual);
        bit [63:0] expected;
        if (pending_values.size() == 0)
        begin
            note_failure($sformatf("unexpected result %h", actual));
        end
        else
        begin
            expected = pending_values.pop_front();
            if (actual !== expected)
                note_failure($sformatf("random_value expected %h got %h", expected, actual));
        end
    endfunction

endclass

module tb;

    localparam int          REG_SEED     = 0;
    localparam int          REG_SALT     = 1;
    localparam int          HOLD_CYCLES  = 1500;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          TAIL_CYCLES  = 200;
    localparam int          PHASE_ITEMS  = 104;
    localparam int          NUM_PHASES   = 8;
    localparam bit [63:0]   ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam bit [63:0]   TOP_BIT      = 64'h8000_0000_0000_0000;
    localparam bit [63:0]   ODD_BITS     = 64'h5555_5555_5555_5555;
    localparam bit [63:0]   EVEN_BITS    = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef enum int { FLOW_FREE, FLOW_TX_IDLE, FLOW_RX_STALL, FLOW_BOTH } flow_mode_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [brrg_pkg::ADDR_W-1:0]         paddr = '0;
    logic [brrg_pkg::DATA_W-1:0]         pwdata = '0;
    logic [brrg_pkg::DATA_W-1:0]         prdata;
    logic                                pready;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [2*brrg_pkg::DATA_W-1:0]       s_axis_tdata = '0;  // range_low, range_high
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [brrg_pkg::DATA_W-1:0]         m_axis_tdata;       // random_value

    range_draw_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    bounded_random_range_generator u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always #2 clk = ~clk;

    // Result side: random stalls, plus a long hold-off when asked for
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (holds_served != holds_asked)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_served  <= holds_served + 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_value(m_axis_tdata);
    end

    // Watchdog: cycles with no request or result accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL bounded_random_range_generator");
                $finish;
            end
        end
    end

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void set_flow(flow_mode_t mode);
        case (mode)
            FLOW_FREE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            FLOW_TX_IDLE:  begin tx_idle_pct = 66; rx_stall_pct = 0;  end
            FLOW_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 66; end
            default:       begin tx_idle_pct = 26; rx_stall_pct = 26; end
        endcase
    endfunction

    // Register write then read-back; block must be idle
    task automatic set_register(input int idx, input bit [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= brrg_pkg::ADDR_W'(idx << brrg_pkg::CFG_SEL_BIT);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_SEED)
            sb.seed_reg = value;
        else
            sb.salt_reg = value;
        // read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value)
            sb.note_failure($sformatf("register %0d read %h expected %h", idx, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one request and wait for it to be taken
    task automatic send_request(input bit [63:0] lo, input bit [63:0] hi);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(lo, hi);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_values.size() != 0)
            @(posedge clk);
    endtask

    // Random bounds, weighted towards the interesting range sizes
    task automatic random_request();
        bit [63:0] lo;
        bit [63:0] hi;
        int        pick;
        pick = $urandom_range(0, 99);
        lo   = rand64();
        if (pick < 25)
            hi = lo + 64'($urandom_range(0, 255));
        else if (pick < 45)
            hi = rand64();
        else if (pick < 55)
            hi = lo;
        else if (pick < 60)
        begin
            lo = '0;
            hi = ALL_ONES;
        end
        else if (pick < 72)
            hi = lo + ((64'd1 << $urandom_range(0, 63)) - 64'd1);
        else if (pick < 84)
        begin
            lo = 64'($urandom_range(0, 1000));
            hi = lo + TOP_BIT + 64'($urandom_range(0, 1000));
        end
        else
        begin
            lo = lo >> $urandom_range(0, 63);
            hi = rand64() >> $urandom_range(0, 63);
        end
        if ($urandom_range(0, 1) == 1)
            send_request(hi, lo);
        else
            send_request(lo, hi);
    endtask

    // Main sequence
    initial
    begin
        bit [63:0] dir_lo[$];
        bit [63:0] dir_hi[$];
        bit [63:0] seeds[NUM_PHASES];
        bit [63:0] salts[NUM_PHASES];

        sb = new();
        dir_lo = '{64'd0, ALL_ONES, 64'd0, ALL_ONES, 64'd5, 64'd0, 64'd0, 64'd0,
                   64'd1, ALL_ONES - 64'd1, ODD_BITS, EVEN_BITS, TOP_BIT, 64'd0,
                   ALL_ONES, 64'd0, 64'd123};
        dir_hi = '{64'd0, ALL_ONES, ALL_ONES, 64'd0, 64'd3, 64'd1, TOP_BIT,
                   TOP_BIT - 64'd1, ALL_ONES, ALL_ONES, EVEN_BITS, ODD_BITS, TOP_BIT,
                   64'd2, 64'd1, 64'hFFFF_FFFF, 64'd222};
        seeds = '{ALL_ONES, rand64(), 64'd0, rand64(), TOP_BIT, 64'd1, rand64(), ALL_ONES};
        salts = '{ALL_ONES, rand64(), 64'd0, 64'd1, TOP_BIT, rand64(), EVEN_BITS, rand64()};

        // Reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero seed takes the fallback on the first draw
        set_register(REG_SEED, 64'd0);
        set_register(REG_SALT, 64'd0);
        set_flow(FLOW_FREE);
        foreach (dir_lo[i])
            send_request(dir_lo[i], dir_hi[i]);
        drain_results();

        // Random phases over settings and flow patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_register(REG_SEED, seeds[p]);
            set_register(REG_SALT, salts[p]);
            set_flow(flow_mode_t'(p % 4));
            if (p == 4)
                holds_asked <= holds_asked + 1;
            repeat (PHASE_ITEMS)
                random_request();
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending_values.size() == 0)
            $display("PASS bounded_random_range_generator");
        else
            $display("FAIL bounded_random_range_generator");
        $finish;
    end

endmodule
